// ===== hw/rtl/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types, constants and tables of the Streebog hash block
// ----------------------------------------------------------------------------
package sbh_pkg;

    localparam int NWORDS   = 8;
    localparam int NROUNDS  = 12;
    localparam int WORD_W   = 64;
    localparam int BLOCK_W  = 512;
    localparam int ADDR_W   = 2;

    localparam logic [ADDR_W-1:0] REG_DIGEST_512 = 2'd0;

    typedef struct packed {
        logic        last_word;
        logic [3:0]  valid_bytes;
        logic [63:0] message_word;
    } sbh_in_t;

    typedef struct packed {
        logic        digest_last;
        logic [63:0] digest_word;
    } sbh_out_t;

    // operand selects for the lps unit
    typedef enum logic [2:0] {
        OPA_CHAIN,
        OPA_KEY
    } sbh_opa_t;

    typedef enum logic [2:0] {
        OPB_CNT,
        OPB_BLK,
        OPB_RC,
        OPB_ST,
        OPB_ZERO,
        OPB_SUM
    } sbh_opb_t;

    typedef enum logic [1:0] {
        DST_KEY,
        DST_ST
    } sbh_dst_t;

    // what the compression is run over
    typedef enum logic [1:0] {
        CMP_MSG,
        CMP_PAD,
        CMP_CNT,
        CMP_SUM
    } sbh_cmp_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       restart;
        logic       load_word;
        logic       build_pad;
        logic       lps_go;
        sbh_opa_t   opa;
        sbh_opb_t   opb;
        sbh_dst_t   dst;
        logic [3:0] rc_idx;
        sbh_cmp_t   cmp;
        logic       finish_cmp;
        logic       add_full;
        logic       add_pad;
        logic [2:0] out_idx;
    } sbh_cmd_t;

    typedef struct packed {
        logic [2:0] words_buffered;
        logic       digest_512;
    } sbh_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FULL_K,
        ST_FULL_S,
        ST_ROUND_K,
        ST_ROUND_S,
        ST_LAST_K,
        ST_FIN,
        ST_PADPREP,
        ST_OUT
    } sbh_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    // linear map, entry 0 belongs to bit 63 of a word
    localparam logic [63:0] LIN_MAT [64] = '{
        64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
        64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
        64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
        64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
        64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
        64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
        64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
        64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
        64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
        64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
        64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
        64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
        64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
        64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
        64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
        64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
    };

    localparam logic [511:0] ROUND_C [NROUNDS] = '{
        {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
         64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
        {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
         64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
        {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
         64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
        {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
         64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
        {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
         64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
        {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
         64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
        {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
         64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
        {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
         64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
        {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
         64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
        {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
         64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
        {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
         64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
        {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
         64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
    };

    // one output word of L applied to the substituted bytes
    function automatic logic [63:0] lin_word(input logic [63:0] bytes_in);
        logic [63:0] acc;
        acc = '0;
        for (int t = 0; t < 64; t++) begin
            if (bytes_in[t]) begin
                acc = acc ^ LIN_MAT[63 - t];
            end
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/sbh_datapath.sv =====
// ----------------------------------------------------------------------------
// sbh_datapath
// Chain, counter, checksum, buffer and the shared LPS unit
// ----------------------------------------------------------------------------
module sbh_datapath
    import sbh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  sbh_cmd_t  cmd,
    input  sbh_in_t   in_item,
    input  logic      mode_512,
    output sbh_stat_t stat,
    output logic [63:0] out_word
);

    logic [511:0] chain_reg, cnt_reg, sum_reg, buf_reg, key_reg, st_reg, blk_reg;
    logic [511:0] pad_reg;
    logic [2:0]   wb_reg;
    logic [9:0]   padlen_reg;
    logic [511:0] opa, opb, x, lps;
    logic [511:0] pad_blk;
    logic [511:0] buf_w;
    logic [3:0]   vb;
    logic [6:0]   nbytes;
    logic [2:0]   full_w;
    logic [2:0]   rem;
    logic [511:0] add_v, add_src, add_res;

    // lps operand selection and the unit itself
    always_comb begin
        opa = (cmd.opa == OPA_KEY) ? key_reg : chain_reg;
        case (cmd.opb)
            OPB_CNT:  opb = (cmd.cmp == CMP_MSG || cmd.cmp == CMP_PAD) ? cnt_reg : '0;
            OPB_BLK:  opb = blk_reg;
            OPB_RC:   opb = ROUND_C[cmd.rc_idx];
            OPB_ST:   opb = st_reg;
            default:  opb = '0;
        endcase
        x = opa ^ opb;
        for (int i = 0; i < NWORDS; i++) begin
            logic [63:0] col;
            col = '0;
            for (int j = 0; j < 8; j++) begin
                col[j*8 +: 8] = SBOX[x[(j*64) + i*8 +: 8]];
            end
            lps[i*64 +: 64] = lin_word(col);
        end
    end

    // padded final block from the buffer with the last word merged in
    always_comb begin
        vb = (in_item.valid_bytes > 4'd8) ? 4'd8 : in_item.valid_bytes;
        buf_w = buf_reg;
        if (vb != 4'd0) begin
            buf_w[wb_reg*64 +: 64] = in_item.message_word;
        end
        nbytes = {1'b0, wb_reg, 3'b000} + {3'b000, vb};
        if (nbytes == 7'd64) begin
            nbytes = 7'd0;
        end
        full_w = nbytes[5:3];
        rem    = nbytes[2:0];
        pad_blk = '0;
        for (int k = 0; k < NWORDS; k++) begin
            if (3'(k) < full_w) begin
                pad_blk[k*64 +: 64] = buf_w[k*64 +: 64];
            end else if (3'(k) == full_w) begin
                for (int b = 0; b < 8; b++) begin
                    if (3'(b) < rem) begin
                        pad_blk[k*64 + b*8 +: 8] = buf_w[k*64 + b*8 +: 8];
                    end
                end
                pad_blk[k*64 + rem*8] = 1'b1;
            end
        end
    end

    // counter adder and checksum adder, each one wide add
    always_comb begin
        add_v   = cmd.add_full ? 512'd512 : {502'd0, padlen_reg};
        add_src = cnt_reg + add_v;
        add_res = sum_reg + blk_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            chain_reg <= mode_512 ? '0 : {64{8'h01}};
            cnt_reg   <= '0;
            sum_reg   <= '0;
            wb_reg    <= '0;
        end else begin
            if (cmd.load_word) begin
                buf_reg[wb_reg*64 +: 64] <= in_item.message_word;
                wb_reg <= wb_reg + 3'd1;
            end
            if (cmd.build_pad) begin
                // a full block is staged first when the last word fills it
                if ({1'b0, wb_reg, 3'b000} + {3'b000, vb} == 7'd64) begin
                    buf_reg <= buf_w;
                    blk_reg <= buf_w;
                end else begin
                    blk_reg <= pad_blk;
                end
                // padding block kept once the input item has gone
                pad_reg    <= pad_blk;
                padlen_reg <= {nbytes, 3'b000};
            end
            if (cmd.lps_go) begin
                if (cmd.dst == DST_KEY) key_reg <= lps;
                else                    st_reg  <= lps;
            end
            if (cmd.finish_cmp) begin
                chain_reg <= chain_reg ^ lps ^ st_reg ^ blk_reg;
                if (cmd.add_full || cmd.add_pad) begin
                    cnt_reg <= add_src;
                    sum_reg <= add_res;
                end
            end
            // stage block for the next compression
            if (cmd.cmp == CMP_CNT && !cmd.lps_go) blk_reg <= cnt_reg;
            if (cmd.cmp == CMP_SUM && !cmd.lps_go) blk_reg <= sum_reg;
            if (cmd.cmp == CMP_MSG && !cmd.lps_go && !cmd.build_pad) blk_reg <= buf_reg;
            if (cmd.cmp == CMP_PAD && !cmd.lps_go && !cmd.build_pad) blk_reg <= pad_reg;
        end
    end

    assign stat.words_buffered = wb_reg;
    assign stat.digest_512     = mode_512;
    assign out_word            = chain_reg[cmd.out_idx*64 +: 64];

endmodule

// ===== hw/rtl/sbh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbh_ctrl
// Sequencer for message intake, compressions and digest output
// ----------------------------------------------------------------------------
module sbh_ctrl
    import sbh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr,
    input  logic      s_valid,
    output logic      s_ready,
    input  sbh_in_t   in_item,
    input  sbh_stat_t stat,
    output sbh_cmd_t  cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output logic      out_last
);

    sbh_state_t state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    sbh_cmp_t   cmp_reg, cmp_next;
    logic [2:0] oi_reg, oi_next;
    logic       two_reg, two_next;
    logic [3:0] vb;
    logic       fills;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            cmp_reg   <= CMP_MSG;
            oi_reg    <= '0;
            two_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            cmp_reg   <= cmp_next;
            oi_reg    <= oi_next;
            two_reg   <= two_next;
        end
    end

    always_comb begin
        vb    = (in_item.valid_bytes > 4'd8) ? 4'd8 : in_item.valid_bytes;
        fills = ({1'b0, stat.words_buffered, 3'b000} + {3'b000, vb}) == 7'd64;
    end

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmp_next   = cmp_reg;
        oi_next    = oi_reg;
        two_next   = two_reg;
        cmd        = '0;
        cmd.opa    = OPA_CHAIN;
        cmd.opb    = OPB_CNT;
        cmd.dst    = DST_KEY;
        cmd.cmp    = cmp_reg;
        cmd.rc_idx = rnd_reg;
        cmd.out_idx = oi_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        out_last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!in_item.last_word) begin
                        cmd.load_word = 1'b1;
                        if (stat.words_buffered == 3'd7) begin
                            cmp_next   = CMP_MSG;
                            state_next = ST_PADPREP;
                            two_next   = 1'b0;
                        end
                    end else begin
                        cmd.build_pad = 1'b1;
                        cmp_next   = fills ? CMP_MSG : CMP_PAD;
                        two_next   = 1'b1;
                        state_next = ST_FULL_K;
                    end
                end
            end
            // stages the block register
            ST_PADPREP: begin
                state_next = ST_FULL_K;
            end
            // key = lps(chain ^ cnt), or lps(chain) for the counter and checksum compressions
            ST_FULL_K: begin
                cmd.lps_go = 1'b1;
                state_next = ST_FULL_S;
            end
            ST_FULL_S: begin
                cmd.lps_go = 1'b1;
                cmd.opa = OPA_KEY;
                cmd.opb = OPB_BLK;
                cmd.dst = DST_ST;
                rnd_next = '0;
                state_next = ST_ROUND_K;
            end
            ST_ROUND_K: begin
                cmd.lps_go = 1'b1;
                cmd.opa = OPA_KEY;
                cmd.opb = OPB_RC;
                if (rnd_reg == 4'(NROUNDS - 1)) begin
                    state_next = ST_LAST_K;
                    cmd.lps_go = 1'b0;
                end else begin
                    state_next = ST_ROUND_S;
                end
            end
            ST_ROUND_S: begin
                cmd.lps_go = 1'b1;
                cmd.opa = OPA_KEY;
                cmd.opb = OPB_ST;
                cmd.dst = DST_ST;
                rnd_next = rnd_reg + 4'd1;
                state_next = ST_ROUND_K;
            end
            // final key round folds straight into the chain
            ST_LAST_K: begin
                cmd.opa = OPA_KEY;
                cmd.opb = OPB_RC;
                cmd.finish_cmp = 1'b1;
                cmd.add_full = (cmp_reg == CMP_MSG);
                cmd.add_pad  = (cmp_reg == CMP_PAD);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!two_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    case (cmp_reg)
                        CMP_MSG: cmp_next = CMP_PAD;
                        CMP_PAD: cmp_next = CMP_CNT;
                        CMP_CNT: cmp_next = CMP_SUM;
                        default: cmp_next = CMP_SUM;
                    endcase
                    if (cmp_reg == CMP_SUM) begin
                        oi_next    = stat.digest_512 ? 3'd0 : 3'd4;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_PADPREP;
                    end
                end
            end
            ST_OUT: begin
                m_valid  = 1'b1;
                out_last = (oi_reg == 3'd7);
                if (m_ready) begin
                    oi_next = oi_reg + 3'd1;
                    if (oi_reg == 3'd7) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                        cmp_next    = CMP_MSG;
                        two_next    = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_out_only_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT) else $error("result outside output phase");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("intake while emitting");
    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_reg <= 4'(NROUNDS - 1)) else $error("round counter overrun");

endmodule

// ===== hw/rtl/streebog_hash.sv =====
// ----------------------------------------------------------------------------
// streebog_hash
// Streebog hash with APB mode register and valid/ready message and digest
// ----------------------------------------------------------------------------
// a non-last item is taken while idle; every eighth one adds a compression
// (25 lps steps of the single lps unit plus staging), during which no item is taken
// a last item runs three or four compressions, then 4 or 8 results
// synchronous active-low reset restores the 512-bit mode, zero counter and sum,
// and the initial chain; a digest_512 write restarts the message the same way
module streebog_hash
    import sbh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbh_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sbh_out_t          m_data
);

    logic      mode_reg;
    logic      cfg_wr;
    sbh_cmd_t  cmd;
    sbh_stat_t stat;
    logic [63:0] word;
    logic      last;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_DIGEST_512);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_wr) begin
            mode_reg <= pwdata[0];
        end
    end
    assign prdata = {31'd0, (paddr == REG_DIGEST_512) ? mode_reg : 1'b0};

    sbh_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr(cfg_wr),
        .s_valid(s_valid), .s_ready(s_ready), .in_item(s_data),
        .stat(stat), .cmd(cmd), .m_valid(m_valid), .m_ready(m_ready),
        .out_last(last)
    );

    sbh_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn && !cfg_wr), .cmd(cmd), .in_item(s_data),
        .mode_512(cfg_wr ? pwdata[0] : mode_reg), .stat(stat), .out_word(word)
    );

    assign m_data.digest_word = word;
    assign m_data.digest_last = last;

endmodule
